### rtl/core/avd_pkg.sv
// avd_pkg: shared constants, types and the CORDIC arctangent table
// for the vector angle core. No dependencies.
`default_nettype none
package avd_pkg;
	localparam int COMPONENT_BITS = 16;
	localparam int NORM_BITS      = 15;
	localparam int SQRT_STAGES    = 32;
	localparam int CORDIC_STAGES  = 22;
	localparam int XY_W           = 36;
	localparam int Z_W            = 26;
	localparam int D_W            = 34;

	localparam logic [Z_W-1:0]  BASE_RIGHT  = Z_W'(5898240);
	localparam logic [Z_W-1:0]  T_MAX       = Z_W'(11796480);
	localparam logic [15:0]     ANGLE_MAX   = 16'd46080;
	localparam logic [15:0]     ANGLE_RIGHT = 16'd23040;

	typedef struct packed {
		logic                  valid;
		logic                  zero;
		logic signed [D_W-1:0] d;
	} sqrt_side_t;

	typedef struct packed {
		logic valid;
		logic zero;
		logic obtuse;
	} cordic_side_t;

	function automatic logic [Z_W-1:0] atan_q16(input int i);
		case (i)
			0:       atan_q16 = Z_W'(2949120);
			1:       atan_q16 = Z_W'(1740967);
			2:       atan_q16 = Z_W'(919879);
			3:       atan_q16 = Z_W'(466945);
			4:       atan_q16 = Z_W'(234379);
			5:       atan_q16 = Z_W'(117304);
			6:       atan_q16 = Z_W'(58666);
			7:       atan_q16 = Z_W'(29335);
			8:       atan_q16 = Z_W'(14668);
			9:       atan_q16 = Z_W'(7334);
			10:      atan_q16 = Z_W'(3667);
			11:      atan_q16 = Z_W'(1833);
			12:      atan_q16 = Z_W'(917);
			13:      atan_q16 = Z_W'(458);
			14:      atan_q16 = Z_W'(229);
			15:      atan_q16 = Z_W'(115);
			16:      atan_q16 = Z_W'(57);
			17:      atan_q16 = Z_W'(29);
			18:      atan_q16 = Z_W'(14);
			19:      atan_q16 = Z_W'(7);
			20:      atan_q16 = Z_W'(4);
			21:      atan_q16 = Z_W'(2);
			default: atan_q16 = '0;
		endcase
	endfunction
endpackage
`default_nettype wire

### rtl/core/vector_angle_degrees_core.sv
// vector_angle_degrees_core: angle between two 3D vectors, Q8.8 degrees.
// Pipeline: 7 prep stages, 32 square-root cells, 1 select, 22 CORDIC
// cells, 1 output; one beat accepted every cycle, busy is always low.
// Reset clears the valid pipeline only; results appear on done for one
// cycle and cannot be stalled. Depends on avd_pkg and the cell modules.
`default_nettype none
module vector_angle_degrees_core #(
	parameter int COMPONENT_BITS = avd_pkg::COMPONENT_BITS
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             start,
	output logic                            busy,
	input  wire signed [COMPONENT_BITS-1:0] ax,
	input  wire signed [COMPONENT_BITS-1:0] ay,
	input  wire signed [COMPONENT_BITS-1:0] az,
	input  wire signed [COMPONENT_BITS-1:0] bx,
	input  wire signed [COMPONENT_BITS-1:0] by,
	input  wire signed [COMPONENT_BITS-1:0] bz,
	output logic                            done,
	output logic [15:0]                     angle_deg,
	output logic                            zero_length
);
	localparam int NS = avd_pkg::SQRT_STAGES;
	localparam int NC = avd_pkg::CORDIC_STAGES;
	localparam int XW = avd_pkg::XY_W;
	localparam int ZW = avd_pkg::Z_W;

	avd_pkg::sqrt_side_t   sq_side [NS+1];
	logic [63:0]           sq_n    [NS+1];
	logic [63:0]           sq_res  [NS+1];
	avd_pkg::cordic_side_t cr_side [NC+1];
	logic signed [XW-1:0]  cr_x    [NC+1];
	logic signed [XW-1:0]  cr_y    [NC+1];
	logic signed [ZW-1:0]  cr_z    [NC+1];
	logic                  sel_valid_q;
	logic                  sel_zero_q;
	logic                  sel_obtuse_q;

	assign busy = 1'b0;

	avd_prep #(.COMPONENT_BITS(COMPONENT_BITS)) u_prep (
		.clk(clk), .arst_n(arst_n), .in_valid(start && !busy),
		.ax(ax), .ay(ay), .az(az), .bx(bx), .by(by), .bz(bz),
		.side(sq_side[0]), .csq(sq_n[0])
	);
	assign sq_res[0] = '0;

	for (genvar k = 0; k < NS; k++) begin : g_sqrt
		avd_sqrt_cell #(.K(k)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.side_in(sq_side[k]), .n_in(sq_n[k]), .res_in(sq_res[k]),
			.side_out(sq_side[k+1]), .n_out(sq_n[k+1]), .res_out(sq_res[k+1])
		);
	end

	// quadrant select: keep x non-negative
	assign cr_side[0] = {sel_valid_q, sel_zero_q, sel_obtuse_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_valid_q <= 1'b0;
		end else begin
			sel_valid_q <= sq_side[NS].valid;
		end
	end

	always_ff @(posedge clk) begin
		sel_zero_q   <= sq_side[NS].zero;
		sel_obtuse_q <= sq_side[NS].d[avd_pkg::D_W-1];
		cr_z[0]      <= '0;
		if (!sq_side[NS].d[avd_pkg::D_W-1]) begin
			cr_x[0] <= XW'(sq_side[NS].d);
			cr_y[0] <= $signed({4'b0, sq_res[NS][31:0]});
		end else begin
			cr_x[0] <= $signed({4'b0, sq_res[NS][31:0]});
			cr_y[0] <= -XW'(sq_side[NS].d);
		end
	end

	for (genvar i = 0; i < NC; i++) begin : g_cordic
		avd_cordic_cell #(.I(i)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.side_in(cr_side[i]), .x_in(cr_x[i]), .y_in(cr_y[i]), .z_in(cr_z[i]),
			.side_out(cr_side[i+1]), .x_out(cr_x[i+1]), .y_out(cr_y[i+1]),
			.z_out(cr_z[i+1])
		);
	end

	logic signed [ZW:0] t_sum;
	logic [ZW-1:0]      t_clp;
	logic [ZW-1:0]      t_rnd;
	logic [15:0]        ang_c;

	always_comb begin
		t_sum = (ZW+1)'(cr_z[NC])
		      + (cr_side[NC].obtuse ? $signed({1'b0, avd_pkg::BASE_RIGHT}) : '0);
		if (t_sum[ZW]) begin
			t_clp = '0;
		end else if (ZW'(t_sum) > avd_pkg::T_MAX) begin
			t_clp = avd_pkg::T_MAX;
		end else begin
			t_clp = ZW'(t_sum);
		end
		t_rnd = (t_clp + ZW'(128)) >> 8;
		ang_c = (t_rnd > ZW'(avd_pkg::ANGLE_MAX)) ? avd_pkg::ANGLE_MAX : t_rnd[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cr_side[NC].valid;
		end
	end

	always_ff @(posedge clk) begin
		zero_length <= cr_side[NC].zero;
		angle_deg   <= cr_side[NC].zero ? avd_pkg::ANGLE_RIGHT : ang_c;
	end

	a_zero_right: assert property (@(posedge clk) disable iff (!arst_n)
		done && zero_length |-> angle_deg == avd_pkg::ANGLE_RIGHT)
		else $error("zero-length beat without right angle");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> angle_deg <= avd_pkg::ANGLE_MAX)
		else $error("angle out of range");
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		cr_side[NC].valid |=> done)
		else $error("result beat dropped");
	a_chain: assert property (@(posedge clk) disable iff (!arst_n)
		sq_side[NS].valid |=> cr_side[0].valid)
		else $error("beat lost between sqrt and cordic chains");
endmodule
`default_nettype wire

### rtl/core/avd_prep.sv
// avd_prep: per-vector normalization, dot and cross products, and the
// squared cross length. Depends on avd_pkg.
`default_nettype none
module avd_prep #(
	parameter int COMPONENT_BITS = avd_pkg::COMPONENT_BITS
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             in_valid,
	input  wire signed [COMPONENT_BITS-1:0] ax,
	input  wire signed [COMPONENT_BITS-1:0] ay,
	input  wire signed [COMPONENT_BITS-1:0] az,
	input  wire signed [COMPONENT_BITS-1:0] bx,
	input  wire signed [COMPONENT_BITS-1:0] by,
	input  wire signed [COMPONENT_BITS-1:0] bz,
	output avd_pkg::sqrt_side_t             side,
	output logic [63:0]                     csq
);
	localparam int CB = COMPONENT_BITS;
	localparam int LW = $clog2(CB + 1);
	localparam int SW = CB + avd_pkg::NORM_BITS;

	logic [6:0]            vld_q;
	logic [CB-1:0]         mag_s1 [6];
	logic                  neg_s1 [6];
	logic                  zero_s1;
	logic [CB-1:0]         mag_s2 [6];
	logic                  neg_s2 [6];
	logic [LW-1:0]         len_s2 [2];
	logic                  zero_s2;
	logic signed [15:0]    nrm_s3 [6];
	logic                  zero_s3;
	logic signed [31:0]    prd_s4 [9];
	logic                  zero_s4;
	logic signed [32:0]    crs_s5 [3];
	logic signed [avd_pkg::D_W-1:0] d_s5, d_s6, d_s7;
	logic                  zero_s5, zero_s6, zero_s7;
	logic [61:0]           sq_s6 [3];
	logic [63:0]           csq_s7;

	logic signed [CB-1:0] comp [6];
	logic [LW-1:0]        len_c [2];
	logic [CB-1:0]        orv [2];

	assign comp[0] = ax;
	assign comp[1] = ay;
	assign comp[2] = az;
	assign comp[3] = bx;
	assign comp[4] = by;
	assign comp[5] = bz;

	always_comb begin
		for (int v = 0; v < 2; v++) begin
			orv[v]   = mag_s1[3*v] | mag_s1[3*v+1] | mag_s1[3*v+2];
			len_c[v] = '0;
			for (int k = 0; k < CB; k++) begin
				if (orv[v][k]) begin
					len_c[v] = LW'(k + 1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[5:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		logic [SW-1:0] wide;
		for (int i = 0; i < 6; i++) begin
			neg_s1[i] <= comp[i][CB-1];
			mag_s1[i] <= comp[i][CB-1] ? CB'(-comp[i]) : CB'(comp[i]);
		end
		zero_s1 <= (ax == '0 && ay == '0 && az == '0) || (bx == '0 && by == '0 && bz == '0);

		mag_s2  <= mag_s1;
		neg_s2  <= neg_s1;
		len_s2  <= len_c;
		zero_s2 <= zero_s1;

		for (int i = 0; i < 6; i++) begin
			wide = {mag_s2[i], avd_pkg::NORM_BITS'(0)} >> len_s2[i/3];
			nrm_s3[i] <= neg_s2[i] ? -$signed({1'b0, wide[14:0]})
			                       : $signed({1'b0, wide[14:0]});
		end
		zero_s3 <= zero_s2;

		prd_s4[0] <= nrm_s3[0] * nrm_s3[3];
		prd_s4[1] <= nrm_s3[1] * nrm_s3[4];
		prd_s4[2] <= nrm_s3[2] * nrm_s3[5];
		prd_s4[3] <= nrm_s3[1] * nrm_s3[5];
		prd_s4[4] <= nrm_s3[2] * nrm_s3[4];
		prd_s4[5] <= nrm_s3[2] * nrm_s3[3];
		prd_s4[6] <= nrm_s3[0] * nrm_s3[5];
		prd_s4[7] <= nrm_s3[0] * nrm_s3[4];
		prd_s4[8] <= nrm_s3[1] * nrm_s3[3];
		zero_s4 <= zero_s3;

		d_s5 <= avd_pkg::D_W'(prd_s4[0]) + avd_pkg::D_W'(prd_s4[1])
		      + avd_pkg::D_W'(prd_s4[2]);
		crs_s5[0] <= 33'(prd_s4[3]) - 33'(prd_s4[4]);
		crs_s5[1] <= 33'(prd_s4[5]) - 33'(prd_s4[6]);
		crs_s5[2] <= 33'(prd_s4[7]) - 33'(prd_s4[8]);
		zero_s5 <= zero_s4;

		for (int i = 0; i < 3; i++) begin
			logic [30:0] u;
			u = crs_s5[i][32] ? 31'(-crs_s5[i]) : 31'(crs_s5[i]);
			sq_s6[i] <= u * u;
		end
		d_s6    <= d_s5;
		zero_s6 <= zero_s5;

		csq_s7  <= 64'(sq_s6[0]) + 64'(sq_s6[1]) + 64'(sq_s6[2]);
		d_s7    <= d_s6;
		zero_s7 <= zero_s6;
	end

	assign side.valid = vld_q[6];
	assign side.zero  = zero_s7;
	assign side.d     = d_s7;
	assign csq        = csq_s7;
endmodule
`default_nettype wire

### rtl/core/avd_sqrt_cell.sv
// avd_sqrt_cell: one bit-pair step of the integer square root chain.
// Depends on avd_pkg.
`default_nettype none
module avd_sqrt_cell #(
	parameter int K = 0
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  avd_pkg::sqrt_side_t side_in,
	input  wire [63:0]          n_in,
	input  wire [63:0]          res_in,
	output avd_pkg::sqrt_side_t side_out,
	output logic [63:0]         n_out,
	output logic [63:0]         res_out
);
	localparam logic [63:0] BIT = 64'd1 << (62 - 2 * K);

	logic                           valid_q;
	logic                           zero_q;
	logic signed [avd_pkg::D_W-1:0] d_q;
	logic [63:0]                    trial;

	assign trial    = res_in + BIT;
	assign side_out = {valid_q, zero_q, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= side_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		zero_q <= side_in.zero;
		d_q    <= side_in.d;
		if (n_in >= trial) begin
			n_out   <= n_in - trial;
			res_out <= (res_in >> 1) + BIT;
		end else begin
			n_out   <= n_in;
			res_out <= res_in >> 1;
		end
	end
endmodule
`default_nettype wire

### rtl/core/avd_cordic_cell.sv
// avd_cordic_cell: one vectoring-mode CORDIC rotation step.
// Depends on avd_pkg.
`default_nettype none
module avd_cordic_cell #(
	parameter int I = 0
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  avd_pkg::cordic_side_t                 side_in,
	input  wire signed [avd_pkg::XY_W-1:0]        x_in,
	input  wire signed [avd_pkg::XY_W-1:0]        y_in,
	input  wire signed [avd_pkg::Z_W-1:0]         z_in,
	output avd_pkg::cordic_side_t                 side_out,
	output logic signed [avd_pkg::XY_W-1:0]       x_out,
	output logic signed [avd_pkg::XY_W-1:0]       y_out,
	output logic signed [avd_pkg::Z_W-1:0]        z_out
);
	localparam logic signed [avd_pkg::Z_W-1:0] T = avd_pkg::atan_q16(I);

	logic                            valid_q;
	logic                            zero_q;
	logic                            obtuse_q;
	logic signed [avd_pkg::XY_W-1:0] xs, ys;

	assign xs       = x_in >>> I;
	assign ys       = y_in >>> I;
	assign side_out = {valid_q, zero_q, obtuse_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= side_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		zero_q   <= side_in.zero;
		obtuse_q <= side_in.obtuse;
		if (!y_in[avd_pkg::XY_W-1]) begin
			x_out <= x_in + ys;
			y_out <= y_in - xs;
			z_out <= z_in + T;
		end else begin
			x_out <= x_in - ys;
			y_out <= y_in + xs;
			z_out <= z_in - T;
		end
	end
endmodule
`default_nettype wire
